FILE: rtl/core/ppp_pkg.sv
// Shared types, widths and helpers for the pinhole point projection pipeline.
package ppp_pkg;

  localparam int CW = 44;   // camera-frame coordinate width
  localparam int NW = 64;   // projection numerator width
  localparam int DW = 52;   // |z| * 256 width
  localparam int QW = 16;   // quotient bits, one per cell

  localparam logic [1:0] REG_FOCAL_X  = 2'd0;
  localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
  localparam logic [1:0] REG_CENTER_X = 2'd2;
  localparam logic [1:0] REG_CENTER_Y = 2'd3;

  // packed so that point_x lands in the lowest bits of tdata
  typedef struct packed {
    logic signed [15:0] rot_z;
    logic signed [15:0] rot_y;
    logic signed [15:0] rot_x;
    logic signed [15:0] rot_w;
    logic signed [31:0] pose_z;
    logic signed [31:0] pose_y;
    logic signed [31:0] pose_x;
    logic signed [31:0] point_z;
    logic signed [31:0] point_y;
    logic signed [31:0] point_x;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic signed [CW-1:0] rz;
  } cam_t;

  typedef struct packed {
    logic [19:0] focal_x;
    logic [19:0] focal_y;
    logic [19:0] center_x;
    logic [19:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic          neg;
    logic          sat;
    logic          satneg;
    logic [QW-1:0] quo;
    logic [NW-1:0] rem;
  } axis_t;

  typedef struct packed {
    axis_t       u;
    axis_t       v;
    logic [DW-1:0] den;
    logic [31:0] depth;
    logic        dflag;
  } cell_t;

  // round half up from Q.28 to Q.14
  function automatic logic signed [21:0] round14(input logic signed [35:0] val);
    logic signed [35:0] tmp;
    tmp = (val + 36'sd8192) >>> 14;
    return tmp[21:0];
  endfunction

endpackage

FILE: rtl/core/ppp_rot.sv
// Rotation front end: matrix from quaternion, matrix-vector product, pose subtract.
module ppp_rot import ppp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  out_valid,
  input  logic  out_ready,
  output cam_t  out_cam
);

  logic v1, v2, v3, r1, r2, r3;
  logic signed [21:0] m [9];
  logic signed [21:0] m_next [9];
  logic signed [31:0] pt [3];
  logic signed [31:0] ps1 [3];
  logic signed [31:0] ps2 [3];
  logic signed [53:0] pr [9];

  assign r3 = !v3 || out_ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready = r1;
  assign out_valid = v3;

  always_comb begin
    logic signed [35:0] w, x, y, z, one;
    w = 36'(in_item.rot_w);
    x = 36'(in_item.rot_x);
    y = 36'(in_item.rot_y);
    z = 36'(in_item.rot_z);
    one = 36'sd268435456;
    m_next[0] = round14(one - 2 * (y * y + z * z));
    m_next[1] = round14(2 * (x * y + w * z));
    m_next[2] = round14(2 * (x * z - w * y));
    m_next[3] = round14(2 * (x * y - w * z));
    m_next[4] = round14(one - 2 * (x * x + z * z));
    m_next[5] = round14(2 * (y * z + w * x));
    m_next[6] = round14(2 * (x * z + w * y));
    m_next[7] = round14(2 * (y * z - w * x));
    m_next[8] = round14(one - 2 * (x * x + y * y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  // stage 1: matrix entries
  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      m <= m_next;
      pt[0] <= in_item.point_x;
      pt[1] <= in_item.point_y;
      pt[2] <= in_item.point_z;
      ps1[0] <= in_item.pose_x;
      ps1[1] <= in_item.pose_y;
      ps1[2] <= in_item.pose_z;
    end
  end

  // stage 2: nine products
  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      for (int i = 0; i < 9; i++) begin
        pr[i] <= 54'(m[i]) * 54'(pt[i % 3]);
      end
      ps2 <= ps1;
    end
  end

  // stage 3: row sums, round to Q16.16, subtract position
  always_ff @(posedge clk) begin
    if (r3 && v2) begin
      logic signed [55:0] s0, s1, s2;
      logic signed [55:0] t0, t1, t2;
      s0 = 56'(pr[0]) + 56'(pr[1]) + 56'(pr[2]);
      s1 = 56'(pr[3]) + 56'(pr[4]) + 56'(pr[5]);
      s2 = 56'(pr[6]) + 56'(pr[7]) + 56'(pr[8]);
      t0 = (s0 + 56'sd8192) >>> 14;
      t1 = (s1 + 56'sd8192) >>> 14;
      t2 = (s2 + 56'sd8192) >>> 14;
      out_cam.rx <= CW'(t0) - CW'(ps2[0]);
      out_cam.ry <= CW'(t1) - CW'(ps2[1]);
      out_cam.rz <= CW'(t2) - CW'(ps2[2]);
    end
  end

endmodule

FILE: rtl/core/ppp_proj.sv
// Projection set-up: numerators, magnitudes, saturation checks, divider seed.
module ppp_proj import ppp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  in_valid,
  output logic  in_ready,
  input  cam_t  in_cam,
  output logic  out_valid,
  input  logic  out_ready,
  output cell_t out_cell
);

  logic v4, v5, v6, r4, r5, r6;
  logic signed [NW-1:0] ax, bx, ay, by, nx, ny;
  logic signed [CW-1:0] z4, z5;
  logic cxn4, cyn4, cxn5, cyn5;

  assign r6 = !v6 || out_ready;
  assign r5 = !v5 || r6;
  assign r4 = !v4 || r5;
  assign in_ready = r4;
  assign out_valid = v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (r4) v4 <= in_valid;
      if (r5) v5 <= v4;
      if (r6) v6 <= v5;
    end
  end

  // stage 4: x*focal and center*z for both axes
  always_ff @(posedge clk) begin
    if (r4 && in_valid) begin
      ax <= NW'(in_cam.rx) * NW'(signed'({1'b0, cfg.focal_x}));
      bx <= NW'(in_cam.rz) * NW'(signed'({1'b0, cfg.center_x}));
      ay <= NW'(in_cam.ry) * NW'(signed'({1'b0, cfg.focal_y}));
      by <= NW'(in_cam.rz) * NW'(signed'({1'b0, cfg.center_y}));
      z4 <= in_cam.rz;
      cxn4 <= in_cam.rx[CW-1];
      cyn4 <= in_cam.ry[CW-1];
    end
  end

  // stage 5: numerators
  always_ff @(posedge clk) begin
    if (r5 && v4) begin
      nx <= ax + bx;
      ny <= ay + by;
      z5 <= z4;
      cxn5 <= cxn4;
      cyn5 <= cyn4;
    end
  end

  // stage 6: magnitudes, zero depth and overflow, depth clamp
  always_ff @(posedge clk) begin
    if (r6 && v5) begin
      logic [CW-1:0] za;
      logic [DW-1:0] den;
      logic [NW-1:0] mx, my;
      logic zero, hi, lo;
      za = z5[CW-1] ? CW'(-z5) : CW'(z5);
      den = {za, 8'b0};
      mx = nx[NW-1] ? NW'(-nx) : NW'(nx);
      my = ny[NW-1] ? NW'(-ny) : NW'(ny);
      zero = (z5 == '0);
      hi = (z5 > CW'(32'sh7fffffff));
      lo = (z5 < CW'(32'sh80000000));
      out_cell.den <= den;
      out_cell.u.neg <= nx[NW-1] ^ z5[CW-1];
      out_cell.u.sat <= zero || ({4'b0, mx[NW-1:16]} >= den);
      out_cell.u.satneg <= zero ? cxn5 : (nx[NW-1] ^ z5[CW-1]);
      out_cell.u.quo <= '0;
      out_cell.u.rem <= mx;
      out_cell.v.neg <= ny[NW-1] ^ z5[CW-1];
      out_cell.v.sat <= zero || ({4'b0, my[NW-1:16]} >= den);
      out_cell.v.satneg <= zero ? cyn5 : (ny[NW-1] ^ z5[CW-1]);
      out_cell.v.quo <= '0;
      out_cell.v.rem <= my;
      out_cell.depth <= hi ? 32'h7fffffff : (lo ? 32'h80000000 : z5[31:0]);
      out_cell.dflag <= hi || lo;
    end
  end

endmodule

FILE: rtl/core/ppp_cell.sv
// One restoring-division cell: settles one quotient bit for both pixel axes.
module ppp_cell import ppp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    bitpos,
  input  logic          in_valid,
  output logic          in_ready,
  input  cell_t         in_cell,
  output logic          out_valid,
  input  logic          out_ready,
  output cell_t         out_cell
);

  logic   vld;
  cell_t  cell_next;

  assign in_ready = !vld || out_ready;
  assign out_valid = vld;

  function automatic axis_t step(input axis_t a, input logic [DW-1:0] den,
                                 input logic [3:0] sh);
    logic [67:0] trial;
    axis_t r;
    trial = {4'b0, a.rem} - ({16'b0, den} << sh);
    r = a;
    r.quo = {a.quo[QW-2:0], !trial[67]};
    if (!trial[67]) r.rem = trial[NW-1:0];
    return r;
  endfunction

  always_comb begin
    cell_next = in_cell;
    cell_next.u = step(in_cell.u, in_cell.den, bitpos);
    cell_next.v = step(in_cell.v, in_cell.den, bitpos);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else if (in_ready) vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) out_cell <= cell_next;
  end

endmodule

FILE: rtl/core/pinhole_point_projection.sv
// Top level of the pinhole point projection: config registers, pipeline, output stage.
//
// Projects one world point per transfer through a camera pose (position plus unit
// quaternion in Q1.14) and the intrinsics held in four APB registers (Q12.8 focal
// lengths and principal point, at byte addresses 0, 4, 8, 12). A new point is taken
// every cycle while m_tready lets results drain. A point passes through the rotation
// stages, the numerator and saturation stages, a chain of division cells that each
// settle one quotient bit of both pixels, and the output register. Every stage has
// its own valid and a ready that ripples back from m_tready, so bubbles close up
// behind a stalled result and full rate resumes as soon as m_tready is high again.
// Zero depth or a clamped pixel or depth sets out_of_range. Registers should only
// be written while no point is in flight.
module pinhole_point_projection import ppp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, pose_x, pose_y, pose_z, rot_w, rot_x, rot_y, rot_z
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pixel_u, pixel_v, depth
  output logic [63:0]  m_tdata,
  // out_of_range
  output logic [0:0]   m_tuser
);

  cfg_t  cfg;
  item_t item;
  cam_t  cam;
  logic  rot_valid, rot_ready;

  logic  cv [QW+1];
  logic  cr [QW+1];
  cell_t cd [QW+1];

  logic  ovld, ordy;
  logic [15:0] pu_next, pv_next;
  logic fu, fv;

  // config port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.focal_x  <= 20'd128000;
      cfg.focal_y  <= 20'd128000;
      cfg.center_x <= 20'd81920;
      cfg.center_y <= 20'd61440;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_FOCAL_X:  cfg.focal_x  <= pwdata[19:0];
        REG_FOCAL_Y:  cfg.focal_y  <= pwdata[19:0];
        REG_CENTER_X: cfg.center_x <= pwdata[19:0];
        REG_CENTER_Y: cfg.center_y <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FOCAL_X:  prdata = {12'b0, cfg.focal_x};
      REG_FOCAL_Y:  prdata = {12'b0, cfg.focal_y};
      REG_CENTER_X: prdata = {12'b0, cfg.center_x};
      REG_CENTER_Y: prdata = {12'b0, cfg.center_y};
      default:      prdata = '0;
    endcase
  end

  // rotation and projection set-up
  assign item = item_t'(s_tdata);

  ppp_rot u_rot (
    .clk, .rst,
    .in_valid (s_tvalid), .in_ready (s_tready), .in_item (item),
    .out_valid (rot_valid), .out_ready (rot_ready), .out_cam (cam)
  );

  ppp_proj u_proj (
    .clk, .rst, .cfg,
    .in_valid (rot_valid), .in_ready (rot_ready), .in_cam (cam),
    .out_valid (cv[0]), .out_ready (cr[0]), .out_cell (cd[0])
  );

  // division chain, most significant quotient bit first
  for (genvar g = 0; g < QW; g++) begin : g_cell
    ppp_cell u_cell (
      .clk, .rst,
      .bitpos (4'(QW - 1 - g)),
      .in_valid (cv[g]), .in_ready (cr[g]), .in_cell (cd[g]),
      .out_valid (cv[g+1]), .out_ready (cr[g+1]), .out_cell (cd[g+1])
    );
  end

  // sign, clamp to 16 bits
  function automatic logic [16:0] finish(input axis_t a);
    logic [15:0] p;
    logic f;
    f = 1'b0;
    if (a.sat) begin
      p = a.satneg ? 16'h8000 : 16'h7fff;
      f = 1'b1;
    end else if (!a.neg) begin
      if (a.quo > 16'd32767) begin
        p = 16'h7fff;
        f = 1'b1;
      end else begin
        p = a.quo;
      end
    end else begin
      if (a.quo > 16'd32768) begin
        p = 16'h8000;
        f = 1'b1;
      end else begin
        p = 16'(-{1'b0, a.quo});
      end
    end
    return {f, p};
  endfunction

  assign {fu, pu_next} = finish(cd[QW].u);
  assign {fv, pv_next} = finish(cd[QW].v);

  // output register
  assign ordy = !ovld || m_tready;
  assign cr[QW] = ordy;
  assign m_tvalid = ovld;

  always_ff @(posedge clk) begin
    if (rst) ovld <= 1'b0;
    else if (ordy) ovld <= cv[QW];
  end

  always_ff @(posedge clk) begin
    if (ordy && cv[QW]) begin
      m_tdata <= {cd[QW].depth, pv_next, pu_next};
      m_tuser <= fu || fv || cd[QW].dflag;
    end
  end

endmodule

FILE: dv/pinhole_point_projection_tb.sv
// Testbench for the pinhole point projection: directed and random points, checked per transfer.

class projection_scoreboard;
  logic [15:0] exp_u_q[$];
  logic [15:0] exp_v_q[$];
  logic [31:0] exp_depth_q[$];
  logic        exp_oor_q[$];
  int          mismatches;

  function new();
    mismatches = 0;
  endfunction

  function void note_point(logic [15:0] u, logic [15:0] v, logic [31:0] d, logic f);
    exp_u_q.push_back(u);
    exp_v_q.push_back(v);
    exp_depth_q.push_back(d);
    exp_oor_q.push_back(f);
  endfunction

  function void check_pixel(logic [63:0] data, logic oor);
    logic [15:0] u;
    logic [15:0] v;
    logic [31:0] d;
    logic        f;
    if (exp_u_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h oor=%0d", data, oor);
      return;
    end
    u = exp_u_q.pop_front();
    v = exp_v_q.pop_front();
    d = exp_depth_q.pop_front();
    f = exp_oor_q.pop_front();
    if (data[15:0] !== u || data[31:16] !== v || data[63:32] !== d || oor !== f) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp u=%h v=%h d=%h oor=%0d, got u=%h v=%h d=%h oor=%0d",
                 u, v, d, f, data[15:0], data[31:16], data[63:32], oor);
    end
  endfunction

  function int pending();
    return exp_u_q.size();
  endfunction
endclass

module pinhole_point_projection_tb;
  import ppp_pkg::*;

  localparam int LATENCY = 23;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic [0:0]   m_tuser;

  // intrinsics mirrored from what the test writes
  logic [19:0] fx_cfg, fy_cfg, cx_cfg, cy_cfg;
  // idle percentages for the current phase
  int send_idle_pct;
  int recv_stall_pct;
  int cycles;
  projection_scoreboard sb;

  pinhole_point_projection u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // floor division by 2^14 after the half-up bias
  function automatic longint round_q14(longint val);
    return (val + 64'sd8192) >>> 14;
  endfunction

  // one pixel axis: exact truncating divide, zero depth and clamp both flag
  function automatic longint pixel_axis(longint c, longint z, longint focal,
                                        longint center, inout logic flag);
    longint q;
    if (z == 0) begin
      flag = 1'b1;
      return (c < 0) ? -32768 : 32767;
    end
    q = (c * focal + center * z) / (z * 256);
    if (q > 32767) begin
      flag = 1'b1;
      return 32767;
    end
    if (q < -32768) begin
      flag = 1'b1;
      return -32768;
    end
    return q;
  endfunction

  // predicted projection of one point under one pose
  function automatic void project_point(item_t it, output logic [15:0] pu,
                                        output logic [15:0] pv, output logic [31:0] pd,
                                        output logic flag);
    longint px, py, pz, w, x, y, z, one;
    longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
    longint rx, ry, rz, u, v, d;
    px = it.point_x; py = it.point_y; pz = it.point_z;
    w = it.rot_w; x = it.rot_x; y = it.rot_y; z = it.rot_z;
    one = 64'sd1 << 28;
    flag = 1'b0;
    m00 = round_q14(one - 2 * (y * y + z * z));
    m01 = round_q14(2 * (x * y + w * z));
    m02 = round_q14(2 * (x * z - w * y));
    m10 = round_q14(2 * (x * y - w * z));
    m11 = round_q14(one - 2 * (x * x + z * z));
    m12 = round_q14(2 * (y * z + w * x));
    m20 = round_q14(2 * (x * z + w * y));
    m21 = round_q14(2 * (y * z - w * x));
    m22 = round_q14(one - 2 * (x * x + y * y));
    rx = round_q14(m00 * px + m01 * py + m02 * pz) - longint'(it.pose_x);
    ry = round_q14(m10 * px + m11 * py + m12 * pz) - longint'(it.pose_y);
    rz = round_q14(m20 * px + m21 * py + m22 * pz) - longint'(it.pose_z);
    u = pixel_axis(rx, rz, longint'(fx_cfg), longint'(cx_cfg), flag);
    v = pixel_axis(ry, rz, longint'(fy_cfg), longint'(cy_cfg), flag);
    d = rz;
    if (d > 64'sd2147483647) begin
      d = 64'sd2147483647;
      flag = 1'b1;
    end
    if (d < -64'sd2147483648) begin
      d = -64'sd2147483648;
      flag = 1'b1;
    end
    pu = u[15:0];
    pv = v[15:0];
    pd = d[31:0];
  endfunction

  // APB write: setup then access cycle
  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= {12'h000, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_FOCAL_X:  fx_cfg = val;
      REG_FOCAL_Y:  fy_cfg = val;
      REG_CENTER_X: cx_cfg = val;
      REG_CENTER_Y: cy_cfg = val;
      default: ;
    endcase
  endtask

  task automatic set_intrinsics(logic [19:0] fx, logic [19:0] fy,
                                logic [19:0] cx, logic [19:0] cy);
    write_reg(REG_FOCAL_X, fx);
    write_reg(REG_FOCAL_Y, fy);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
  endtask

  // offer one point; prediction is made at acceptance so config is current
  task automatic send_point(item_t it);
    logic [15:0] pu, pv;
    logic [31:0] pd;
    logic        f;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= it;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    project_point(it, pu, pv, pd, f);
    sb.note_point(pu, pv, pd, f);
  endtask

  // drain pipeline before any register write
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [15:0] unit_comp();
    // mostly near-unit quaternion components, sometimes anything
    if ($urandom_range(3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(32768)) - 16384);
  endfunction

  function automatic logic [31:0] coord();
    case ($urandom_range(4))
      0: return $urandom;
      default: return 32'($signed($urandom_range(32'h00200000)) - 32'sh00100000);
    endcase
  endfunction

  function automatic item_t random_point();
    item_t it;
    it.point_x = coord(); it.point_y = coord(); it.point_z = coord();
    it.pose_x = coord(); it.pose_y = coord(); it.pose_z = coord();
    // in front of the camera most of the time
    if ($urandom_range(3) != 0) it.point_z = 32'($urandom_range(32'h01000000, 32'h00010000));
    if ($urandom_range(3) != 0) begin
      it.rot_w = 16'sd16384; it.rot_x = '0; it.rot_y = '0; it.rot_z = '0;
      if ($urandom_range(1)) begin
        it.rot_w = unit_comp(); it.rot_x = unit_comp();
        it.rot_y = unit_comp(); it.rot_z = unit_comp();
      end
    end else begin
      it.rot_w = unit_comp(); it.rot_x = unit_comp();
      it.rot_y = unit_comp(); it.rot_z = unit_comp();
    end
    if ($urandom_range(15) == 0) it.pose_z = it.point_z; // zero depth with identity pose
    return it;
  endfunction

  task automatic directed_points();
    item_t it;
    it = '0; it.rot_w = 16'sd16384;
    it.point_z = 32'sh00010000;
    send_point(it);                                   // on axis
    it.point_x = 32'sh00008000; it.point_y = -32'sh00004000;
    send_point(it);
    it.point_z = '0; it.pose_z = '0;
    send_point(it);                                   // zero depth, mixed signs
    it.point_x = -32'sd5; it.point_y = 32'sd0;
    send_point(it);
    it.point_z = 32'sd1; it.point_x = 32'sh7fffffff;
    send_point(it);                                   // pixel overflow
    it.point_x = 32'sh80000000; it.point_y = 32'sh7fffffff;
    send_point(it);
    it.point_z = 32'sh7fffffff; it.pose_z = 32'sh80000000;
    send_point(it);                                   // depth overflow
    it.point_z = 32'sh80000000; it.pose_z = 32'sh7fffffff;
    send_point(it);
    it.point_z = -32'sh00020000; it.pose_z = '0;
    send_point(it);                                   // behind the camera
    it = '1;
    send_point(it);
    it = '0; it.point_x = 32'sh7fffffff; it.point_y = 32'sh80000000;
    it.point_z = 32'sh7fffffff;
    it.rot_w = 16'sh7fff; it.rot_x = 16'sh8000; it.rot_y = 16'sh7fff; it.rot_z = 16'sh8000;
    send_point(it);                                   // non-unit quaternion extremes
    it.rot_w = 16'sh8000; it.rot_x = 16'sh7fff; it.rot_y = 16'sh8000; it.rot_z = 16'sh7fff;
    send_point(it);
    it.rot_w = '0; it.rot_x = 16'sd16384; it.rot_y = '0; it.rot_z = '0;
    it.point_z = 32'sh00030000; it.pose_x = 32'sh80000000; it.pose_y = 32'sh7fffffff;
    send_point(it);                                   // half-turn about x
    it.rot_x = '0; it.rot_y = 16'sd11585; it.rot_w = 16'sd11585;
    send_point(it);
  endtask

  // hold m_tready per cycle according to the current stall rate
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // check every result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata, m_tuser[0]);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    sb = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fx_cfg = 20'd128000; fy_cfg = 20'd128000; cx_cfg = 20'd81920; cy_cfg = 20'd61440;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_points();
    wait_idle();

    // phases sweep idle patterns and intrinsics, extremes among them
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      case (phase)
        0: set_intrinsics(20'd128000, 20'd128000, 20'd81920, 20'd61440);
        1: set_intrinsics(20'hfffff, 20'hfffff, 20'hfffff, 20'hfffff);
        2: set_intrinsics(20'd0, 20'd0, 20'd0, 20'd0);
        3: set_intrinsics(20'hfffff, 20'd0, 20'd0, 20'hfffff);
        default: set_intrinsics(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
      endcase
      repeat (88) send_point(random_point());
      wait_idle();
    end

    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/ppp_pkg.sv
rtl/core/ppp_rot.sv
rtl/core/ppp_proj.sv
rtl/core/ppp_cell.sv
rtl/core/pinhole_point_projection.sv
dv/pinhole_point_projection_tb.sv
